@@ hdl/mssp_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor speed smoother package
// Shared widths, constants, register codes and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mssp_pkg;

    // Block size.
    localparam int MOTORS        = 6;
    localparam int HISTORY_DEPTH = 10;
    localparam int DUTY_BITS     = 11;

    // Field widths.
    localparam int MOTOR_W = 3;
    localparam int SPEED_W = 16;
    localparam int WIN_W   = 4;
    localparam int CNT_W   = 12;
    localparam int LED_W   = 8;

    // History memory.
    localparam int HIST_ENTRIES = MOTORS * HISTORY_DEPTH;
    localparam int ADDR_W       = $clog2(HIST_ENTRIES);
    localparam int WINDOW_W     = MOTORS * WIN_W;

    // Arithmetic widths.
    localparam int VAL_W      = SPEED_W + 1;
    localparam int SUM_MAG_W  = $clog2(HISTORY_DEPTH * (2 ** (SPEED_W - 1)) + 1);
    localparam int SUM_W      = SUM_MAG_W + 1;
    localparam int LED_NUM_W  = DUTY_BITS + LED_W;
    localparam int DIV_A_W    = (SUM_MAG_W > LED_NUM_W) ? SUM_MAG_W : LED_NUM_W;
    localparam int DIVIDEND_W = (DIV_A_W > CNT_W) ? DIV_A_W : CNT_W;
    localparam int DIVISOR_W  = DUTY_BITS;
    localparam int DIV_STEP_W = $clog2(DIVIDEND_W);

    // Reset values and constants.
    localparam int LIMIT_RESET = 512;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = {MOTORS{WIN_W'(1)}};
    localparam int LED_FULL     = 255;
    localparam int SPAN_NUM     = 85;
    localparam int SPAN_DEN     = 100;
    localparam int SPAN_X_W     = DUTY_BITS + 7;
    localparam int SPAN_SHIFT   = 24;
    localparam int SPAN_RECIP   = (2 ** SPAN_SHIFT) / SPAN_DEN + 1;
    localparam int SPAN_RECIP_W = 18;
    localparam int SPAN_PROD_W  = SPAN_X_W + SPAN_RECIP_W;

    // Stream payload widths.
    localparam int S_TDATA_W = ((MOTOR_W + SPEED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((MOTOR_W + 1 + DUTY_BITS + 2 * LED_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 3'd6;

    // Command kinds.
    localparam logic ACT_SMOOTH = 1'b0;
    localparam logic ACT_DIRECT = 1'b1;

    typedef logic [MOTORS-1:0][DUTY_BITS-1:0] limit_arr_t;

    typedef enum logic [1:0] {
        DIV_MOD,
        DIV_AVG,
        DIV_LED
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        div_op_t div_op;
        logic    write_hist;
        logic    clear_row;
        logic    sum_start;
        logic    rd_issue;
        logic    avg_take;
        logic    clamp_take;
        logic    led_take;
        logic    led_zero;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic rd_last;
        logic span_zero;
    } status_t;

endpackage

@@ hdl/motor_speed_smoother_pwm_unit.sv @@
// ----------------------------------------------------------------------------
// Motor speed smoother and sign-magnitude PWM driver
//
//   Channel   Dir  Handshake            Contents
//   s_        in   s_tvalid/s_tready    one speed command per beat
//   m_        out  m_tvalid/m_tready    one PWM/LED result per beat
//   APB       in   psel/penable/pready  duty limits and averaging windows
//
// A smoothed command runs the shared 19-step serial divider up to three
// times (counter mod N, N being the motor's window, the mean, and the LED
// ratio) and the sum reads one history entry per cycle from the
// single-port history memory. A direct command uses at most one divider
// pass, the LED ratio. Reset is synchronous and active low; it clears
// the history through per-entry valid bits, so no clearing pass is needed.
// A new command is taken while a finished result still waits on m_tready.
// ----------------------------------------------------------------------------
module motor_speed_smoother_pwm_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Command stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] motor_index, [18:3] speed_command, upper bits zero.
    input  logic [mssp_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] action: 0 smoothed set, 1 direct set.
    input  logic                             s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] motor_id, [3] direction, [14:4] duty, [22:15] led_red,
    // [30:23] led_green, upper bits zero.
    output logic [mssp_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mssp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mssp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mssp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mssp_pkg::*;

    limit_arr_t           limits;
    logic [WINDOW_W-1:0]  windows;
    cmd_t                 cmd;
    status_t              status;
    logic [MOTOR_W-1:0]   in_motor;
    logic [SPEED_W-1:0]   in_speed;

    // Unpack the command beat.
    assign in_motor = s_tdata[MOTOR_W-1:0];
    assign in_speed = s_tdata[MOTOR_W +: SPEED_W];

    // Limits and windows must change only while the block is idle; the block
    // does not enforce this. The datapath samples them when a command is loaded.
    mssp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits),
        .windows (windows)
    );

    // The controller also drops commands for motors that do not exist:
    // they are accepted in the idle state and produce nothing.
    mssp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_motor  (in_motor),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mssp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_motor (in_motor),
        .in_speed (in_speed),
        .limits   (limits),
        .windows  (windows),
        .out_data (m_tdata)
    );

`ifndef SYNTHESIS
    // A valid command for a real motor starts work, so the input side closes.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[MOTOR_W-1:0] < MOTOR_W'(MOTORS)))
        |=> !s_tready)
        else $error("input still ready after accepting a command");

    // A result always names a real motor and never exceeds its duty limit.
    a_duty_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] < MOTOR_W'(MOTORS))
                     && (m_tdata[14:4] <= limits[m_tdata[2:0]]))
        else $error("result duty above the motor limit");

    // A forward direction implies a nonzero duty.
    a_dir_needs_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[14:4] != '0))
        else $error("direction set with zero duty");

    // Red and green add up to the full scale or one less, or green is off past the span.
    a_led_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:23] == '0)
                     || (({1'b0, m_tdata[22:15]} + {1'b0, m_tdata[30:23]}) == 9'd255)
                     || (({1'b0, m_tdata[22:15]} + {1'b0, m_tdata[30:23]}) == 9'd254))
        else $error("LED colors do not split the full scale");
`endif

endmodule

@@ hdl/mssp_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the per-motor duty limits and the packed
// averaging windows.
// ----------------------------------------------------------------------------
module mssp_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mssp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mssp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mssp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output mssp_pkg::limit_arr_t             limits,
    output logic [mssp_pkg::WINDOW_W-1:0]    windows
);
    import mssp_pkg::*;

    limit_arr_t            limit_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOTORS; k++) begin
                limit_reg[k] <= DUTY_BITS'(LIMIT_RESET);
            end
            window_reg <= WINDOW_RESET;
        end else if (wr_en) begin
            for (int k = 0; k < MOTORS; k++) begin
                if (reg_idx == REG_IDX_W'(k)) begin
                    limit_reg[k] <= pwdata[DUTY_BITS-1:0];
                end
            end
            if (reg_idx == REG_WINDOW) begin
                window_reg <= pwdata[WINDOW_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int k = 0; k < MOTORS; k++) begin
            if (reg_idx == REG_IDX_W'(k)) begin
                prdata = APB_DATA_W'(limit_reg[k]);
            end
        end
        if (reg_idx == REG_WINDOW) begin
            prdata = APB_DATA_W'(window_reg);
        end
    end

    assign limits  = limit_reg;
    assign windows = window_reg;

endmodule

@@ hdl/mssp_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle; quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module mssp_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [mssp_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [mssp_pkg::DIVISOR_W-1:0]   divisor,
    output logic                             done,
    output logic [mssp_pkg::DIVIDEND_W-1:0]  quotient,
    output logic [mssp_pkg::DIVISOR_W-1:0]   remainder
);
    import mssp_pkg::*;

    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   dvs_reg;
    logic [DIV_STEP_W-1:0]  step_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic [DIVISOR_W:0]     shifted;
    logic [DIVISOR_W+1:0]   diff;
    logic                   fits;

    // The partial remainder stays below the divisor, so one extra bit holds
    // the shifted value and one more catches a negative trial difference.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[DIVISOR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (run_reg) begin
            if (step_reg == DIV_STEP_W'(DIVIDEND_W - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/mssp_dp.sv @@
// ----------------------------------------------------------------------------
// Smoother datapath
// History memory with per-entry valid bits, write counters, running sum,
// clamp, LED span and the shared serial divider.
// ----------------------------------------------------------------------------
module mssp_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mssp_pkg::cmd_t                   cmd,
    output mssp_pkg::status_t                status,
    input  logic [mssp_pkg::MOTOR_W-1:0]     in_motor,
    input  logic [mssp_pkg::SPEED_W-1:0]     in_speed,
    input  mssp_pkg::limit_arr_t             limits,
    input  logic [mssp_pkg::WINDOW_W-1:0]    windows,
    output logic [mssp_pkg::M_TDATA_W-1:0]   out_data
);
    import mssp_pkg::*;

    // Item registers.
    logic [MOTOR_W-1:0]       m_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [DUTY_BITS-1:0]     lim_reg;
    logic [WIN_W-1:0]         n_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic [DUTY_BITS-1:0]     duty_reg;
    logic                     dir_reg;
    logic [LED_W-1:0]         red_reg;
    logic [LED_W-1:0]         green_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    // Selection of the incoming motor's settings.
    logic [WIN_W-1:0]         win_field;
    logic [WIN_W-1:0]         win_sel;
    logic [DUTY_BITS-1:0]     lim_sel;

    // Per-motor write counters.
    logic [CNT_W-1:0]         cnt_reg [MOTORS];
    logic [CNT_W-1:0]         cur_cnt;

    // History memory.
    logic [SPEED_W-1:0]       hist_mem [HIST_ENTRIES];
    logic [HIST_ENTRIES-1:0]  hist_valid_reg;
    logic [ADDR_W-1:0]        row_base;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [WIN_W-1:0]         rd_idx_reg;
    logic                     rd_pend_reg;
    logic [SPEED_W-1:0]       rd_data_reg;
    logic                     rd_valid_reg;
    logic [SPEED_W-1:0]       rd_word;
    logic signed [SUM_W-1:0]  rd_ext;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     acc_neg;
    logic [SUM_W-1:0]         acc_abs;

    // Divider.
    logic [DIVIDEND_W-1:0]    div_a;
    logic [DIVISOR_W-1:0]     div_b;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_quo;
    logic [DIVISOR_W-1:0]     div_rem;

    // Span, clamp and LED.
    logic [SPAN_X_W-1:0]      span_x_reg;
    logic [SPAN_PROD_W-1:0]   span_prod;
    logic [DUTY_BITS-1:0]     span_reg;
    logic signed [VAL_W-1:0]  avg_q;
    logic signed [VAL_W-1:0]  avg_val;
    logic signed [VAL_W-1:0]  lim_s;
    logic signed [VAL_W-1:0]  clamped;
    logic [VAL_W-1:0]         clamp_abs;
    logic [DIVIDEND_W-1:0]    led_num;
    logic [LED_W-1:0]         red_next;
    logic [LED_W-1:0]         green_next;

    always_comb begin
        win_field = '0;
        lim_sel   = '0;
        for (int k = 0; k < MOTORS; k++) begin
            if (in_motor == MOTOR_W'(k)) begin
                win_field = windows[k*WIN_W +: WIN_W];
                lim_sel   = limits[k];
            end
        end
        if (win_field == '0) begin
            win_sel = WIN_W'(1);
        end else if (win_field > WIN_W'(HISTORY_DEPTH)) begin
            win_sel = WIN_W'(HISTORY_DEPTH);
        end else begin
            win_sel = win_field;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg     <= in_motor;
            speed_reg <= in_speed;
            lim_reg   <= lim_sel;
            n_reg     <= win_sel;
        end
    end

    assign cur_cnt = cnt_reg[m_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOTORS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (cmd.write_hist) begin
            cnt_reg[m_reg] <= cur_cnt + 1'b1;
        end
    end

    // Slot = counter mod window comes out of the divider as its remainder.
    assign row_base = ADDR_W'(m_reg) * ADDR_W'(HISTORY_DEPTH);
    assign wr_addr  = row_base + ADDR_W'(div_rem[WIN_W-1:0]);
    assign rd_addr  = row_base + ADDR_W'(rd_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.write_hist) begin
            hist_mem[wr_addr] <= speed_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg  <= hist_mem[rd_addr];
            rd_valid_reg <= hist_valid_reg[rd_addr];
        end
    end

    // An entry never written since reset or since its row was cleared reads
    // as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg <= '0;
        end else begin
            if (cmd.write_hist) begin
                hist_valid_reg[wr_addr] <= 1'b1;
            end
            for (int e = 0; e < HIST_ENTRIES; e++) begin
                if (cmd.clear_row && ((e / HISTORY_DEPTH) == int'(m_reg))) begin
                    hist_valid_reg[e] <= 1'b0;
                end
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;
    assign rd_ext  = {{(SUM_W - SPEED_W){rd_word[SPEED_W-1]}}, rd_word};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end else begin
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.sum_start) begin
                rd_idx_reg <= '0;
            end else if (cmd.rd_issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_start) begin
            acc_reg <= '0;
        end else if (rd_pend_reg) begin
            acc_reg <= acc_reg + rd_ext;
        end
    end

    assign acc_neg = acc_reg[SUM_W-1];
    assign acc_abs = acc_neg ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);

    // Span is 85% of the limit, floor(85 * limit / 100), by reciprocal.
    assign span_prod = SPAN_PROD_W'(span_x_reg) * SPAN_PROD_W'(SPAN_RECIP);

    always_ff @(posedge aclk) begin
        span_x_reg <= SPAN_X_W'(lim_reg) * SPAN_X_W'(SPAN_NUM);
        span_reg   <= span_prod[SPAN_SHIFT +: DUTY_BITS];
    end

    assign led_num = DIVIDEND_W'(duty_reg) * DIVIDEND_W'(LED_FULL);

    always_comb begin
        case (cmd.div_op)
            DIV_MOD: begin
                div_a = DIVIDEND_W'(cur_cnt);
                div_b = DIVISOR_W'(n_reg);
            end
            DIV_AVG: begin
                div_a = DIVIDEND_W'(acc_abs[SUM_MAG_W-1:0]);
                div_b = DIVISOR_W'(n_reg);
            end
            DIV_LED: begin
                div_a = led_num;
                div_b = span_reg;
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    mssp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Mean truncated toward zero: divide the magnitude, then restore the sign.
    assign avg_q   = $signed(div_quo[VAL_W-1:0]);
    assign avg_val = acc_neg ? -avg_q : avg_q;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= {in_speed[SPEED_W-1], in_speed};
        end else if (cmd.avg_take) begin
            value_reg <= avg_val;
        end
    end

    assign lim_s = $signed(VAL_W'(lim_reg));

    always_comb begin
        if (lim_reg == '0) begin
            clamped = '0;
        end else if (value_reg > lim_s) begin
            clamped = lim_s;
        end else if (value_reg < -lim_s) begin
            clamped = -lim_s;
        end else begin
            clamped = value_reg;
        end
        clamp_abs = clamped[VAL_W-1] ? VAL_W'(-clamped) : VAL_W'(clamped);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clamp_take) begin
            duty_reg <= clamp_abs[DUTY_BITS-1:0];
            dir_reg  <= !clamped[VAL_W-1] && (clamped != '0);
        end
    end

    // Green is 255 minus the rounded-up red ratio while the duty is below
    // the span.
    always_comb begin
        if (div_quo > DIVIDEND_W'(LED_FULL)) begin
            red_next = LED_W'(LED_FULL);
        end else begin
            red_next = div_quo[LED_W-1:0];
        end
        if (duty_reg >= span_reg) begin
            green_next = '0;
        end else if (div_rem == '0) begin
            green_next = LED_W'(LED_FULL) - div_quo[LED_W-1:0];
        end else begin
            green_next = LED_W'(LED_FULL - 1) - div_quo[LED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.led_take) begin
            red_reg   <= red_next;
            green_reg <= green_next;
        end else if (cmd.led_zero) begin
            red_reg   <= (duty_reg != '0) ? LED_W'(LED_FULL) : '0;
            green_reg <= (duty_reg != '0) ? '0 : LED_W'(LED_FULL);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= M_TDATA_W'({green_reg, red_reg, duty_reg, dir_reg, m_reg});
        end
    end

    assign out_data         = out_data_reg;
    assign status.div_done  = div_done;
    assign status.rd_last   = (rd_idx_reg == (n_reg - 1'b1));
    assign status.span_zero = (span_reg == '0);

endmodule

@@ hdl/mssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Smoother controller
// Sequences one command through update and averaging, or a row clear for a
// direct command, then clamp and LED division; owns the output valid flag.
// ----------------------------------------------------------------------------
module mssp_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic                          in_action,
    input  logic [mssp_pkg::MOTOR_W-1:0]  in_motor,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  mssp_pkg::status_t             status,
    output mssp_pkg::cmd_t                cmd
);
    import mssp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_MOD_GO   = 12'b000000000010,
        S_MOD_WAIT = 12'b000000000100,
        S_WRITE    = 12'b000000001000,
        S_SUM      = 12'b000000010000,
        S_SUM_END  = 12'b000000100000,
        S_AVG_GO   = 12'b000001000000,
        S_AVG_WAIT = 12'b000010000000,
        S_CLEAR    = 12'b000100000000,
        S_CLAMP    = 12'b001000000000,
        S_LED_GO   = 12'b010000000000,
        S_LED_WAIT = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   emit_reg;
    logic   emit_next;

    // The result waits in emit_reg until the output register is free.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        emit_next  = emit_reg;
        if (emit_reg) begin
            if (!out_valid_reg || out_ready) begin
                cmd.out_load = 1'b1;
                emit_next    = 1'b0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && (in_motor < MOTOR_W'(MOTORS))) begin
                        cmd.load   = 1'b1;
                        state_next = (in_action == ACT_DIRECT) ? S_CLEAR : S_MOD_GO;
                    end
                end
                S_MOD_GO: begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_MOD;
                    state_next    = S_MOD_WAIT;
                end
                S_MOD_WAIT: begin
                    if (status.div_done) begin
                        state_next = S_WRITE;
                    end
                end
                S_WRITE: begin
                    cmd.write_hist = 1'b1;
                    cmd.sum_start  = 1'b1;
                    state_next     = S_SUM;
                end
                S_SUM: begin
                    cmd.rd_issue = 1'b1;
                    if (status.rd_last) begin
                        state_next = S_SUM_END;
                    end
                end
                S_SUM_END: begin
                    state_next = S_AVG_GO;
                end
                S_AVG_GO: begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_AVG;
                    state_next    = S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (status.div_done) begin
                        cmd.avg_take = 1'b1;
                        state_next   = S_CLAMP;
                    end
                end
                S_CLEAR: begin
                    cmd.clear_row = 1'b1;
                    state_next    = S_CLAMP;
                end
                S_CLAMP: begin
                    cmd.clamp_take = 1'b1;
                    state_next     = S_LED_GO;
                end
                S_LED_GO: begin
                    if (status.span_zero) begin
                        cmd.led_zero = 1'b1;
                        emit_next    = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_LED;
                        state_next    = S_LED_WAIT;
                    end
                end
                S_LED_WAIT: begin
                    if (status.div_done) begin
                        cmd.led_take = 1'b1;
                        emit_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            emit_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            emit_reg      <= emit_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !emit_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ test/motor_speed_smoother_pwm_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed smoother and PWM driver testbench
// Sends speed commands into the block and checks every result beat against
// a local copy of the smoothing, clamping and LED ramp arithmetic. Directed
// tests cover the reset settings, the extreme limits and windows, window
// shrink and growth, and the history slot sequence. Random traffic then runs
// in several handshake pressure phases with new register settings each time.
// ----------------------------------------------------------------------------
module motor_speed_smoother_pwm_unit_test;
    import mssp_pkg::*;

    // Long enough to cover a command that was ignored or is still in flight
    // when the last result arrives.
    localparam int SETTLE_CYCLES    = 120;
    localparam int RANDOM_PER_PHASE = 250;
    // Smoothed commands on one motor, enough to walk its slots many times.
    localparam int COUNTER_ITEMS    = 100;

    // One result beat, declared from the top field down so that motor_id
    // lands in the lowest bits exactly as on m_tdata.
    typedef struct packed {
        logic [LED_W-1:0]     green;
        logic [LED_W-1:0]     red;
        logic [DUTY_BITS-1:0] duty;
        logic                 dir;
        logic [MOTOR_W-1:0]   motor;
    } pwm_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the block's registers and history.
    logic [DUTY_BITS-1:0]      limit_model [MOTORS];
    logic [WINDOW_W-1:0]       window_model;
    logic signed [SPEED_W-1:0] history_model [MOTORS][HISTORY_DEPTH];
    logic [CNT_W-1:0]          count_model [MOTORS];

    // Results predicted for accepted commands, oldest first.
    pwm_result_t pending_pwm [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;

    motor_speed_smoother_pwm_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver drops m_tready at random in the stalling phases.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Averaging window of one motor, with a zero field raised to one and
    // anything above the history depth brought down to it.
    function automatic int window_of(input int m);
        int f;
        f = int'((window_model >> (WIN_W * m)) & 4'hF);
        if (f < 1) f = 1;
        if (f > HISTORY_DEPTH) f = HISTORY_DEPTH;
        return f;
    endfunction

    function automatic logic [WINDOW_W-1:0] with_window(input logic [WINDOW_W-1:0] w,
                                                        input int m, input int n);
        logic [WINDOW_W-1:0] mask;
        mask = WINDOW_W'(4'hF) << (WIN_W * m);
        return (w & ~mask) | ((WINDOW_W'(n) << (WIN_W * m)) & mask);
    endfunction

    // Updates the history for one command and works out its result. Returns
    // zero for a motor number the block does not have.
    function automatic bit predict_pwm(input logic act, input logic [MOTOR_W-1:0] m,
                                       input logic signed [SPEED_W-1:0] spd,
                                       output pwm_result_t r);
        int n, sum, value, lim, duty, span, red, green;
        r = '0;
        if (m >= MOTORS) return 1'b0;
        if (act == ACT_SMOOTH) begin
            n = window_of(m);
            history_model[m][count_model[m] % n] = spd;
            sum = 0;
            for (int i = 0; i < n; i++) sum += history_model[m][i];
            // Integer division truncates toward zero, as the block does.
            value = sum / n;
            count_model[m] = count_model[m] + 1'b1;
        end else begin
            for (int i = 0; i < HISTORY_DEPTH; i++) history_model[m][i] = '0;
            value = spd;
        end
        lim = int'(limit_model[m]);
        if (lim <= 0) value = 0;
        else if (value > lim) value = lim;
        else if (value < -lim) value = -lim;
        duty = (value < 0) ? -value : value;
        span = (lim * SPAN_NUM) / SPAN_DEN;
        if (span == 0) begin
            red   = (duty != 0) ? LED_FULL : 0;
            green = (duty != 0) ? 0 : LED_FULL;
        end else begin
            red = (LED_FULL * duty) / span;
            if (red > LED_FULL) red = LED_FULL;
            green = (duty >= span) ? 0 : (LED_FULL * (span - duty)) / span;
        end
        r.motor = m;
        r.dir   = (value > 0);
        r.duty  = DUTY_BITS'(duty);
        r.red   = LED_W'(red);
        r.green = LED_W'(green);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s: got %0d, wanted %0d", $time, what, got, want);
    endtask

    // Every result beat is compared with the oldest pending prediction.
    always @(posedge aclk) begin : check_result
        pwm_result_t got;
        pwm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(pwm_result_t)-1:0];
            if (pending_pwm.size() == 0) begin
                report_mismatch("result beat with nothing pending", int'(m_tdata), 0);
            end else begin
                want = pending_pwm.pop_front();
                if (got.motor !== want.motor) report_mismatch("motor_id", got.motor, want.motor);
                if (got.dir !== want.dir) report_mismatch("direction", got.dir, want.dir);
                if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
                if (got.red !== want.red) report_mismatch("led_red", got.red, want.red);
                if (got.green !== want.green) report_mismatch("led_green", got.green, want.green);
            end
        end
    end

    // Sends one command beat. The task returns at the edge where the beat
    // was taken and leaves s_tvalid high, so the next call either keeps it
    // high with new data or lowers it for a gap, never both in one step.
    task automatic send_command(input logic act, input logic [MOTOR_W-1:0] m,
                                input logic [SPEED_W-1:0] spd);
        pwm_result_t r;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - MOTOR_W - SPEED_W){1'b0}}, spd, m};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        if (predict_pwm(act, m, spd, r)) pending_pwm.push_back(r);
    endtask

    // Setup and access cycles, then idle with psel low so that the next write
    // starts its setup in a later step.
    task automatic write_register(input int idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == int'(REG_WINDOW)) window_model = value[WINDOW_W-1:0];
        else limit_model[idx] = value[DUTY_BITS-1:0];
        @(posedge aclk);
    endtask

    // Waits until every predicted result has come back, then lets the block
    // finish anything that produces no result.
    task automatic drain_and_settle;
        s_tvalid <= 1'b0;
        while (pending_pwm.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Speed values mixing full-range noise, values around the clamp, the two
    // extremes of the field, and small values that keep averages near zero.
    function automatic logic [SPEED_W-1:0] pick_speed(input logic [MOTOR_W-1:0] m);
        int lim;
        lim = (m < MOTORS) ? int'(limit_model[m]) : LIMIT_RESET;
        case ($urandom_range(3))
            0: return SPEED_W'($urandom);
            1: return SPEED_W'(int'($urandom_range(0, 2 * lim + 16)) - (lim + 8));
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return SPEED_W'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Reset settings: limit 512 and window 1 everywhere, plus the two motor
    // numbers that do not exist.
    task automatic test_reset_defaults;
        send_command(ACT_DIRECT, 3'd0, 16'h7FFF);
        send_command(ACT_DIRECT, 3'd1, 16'h8000);
        send_command(ACT_SMOOTH, 3'd2, 16'd0);
        send_command(ACT_SMOOTH, 3'd3, 16'd1);
        send_command(ACT_SMOOTH, 3'd4, 16'hFFFF);
        // 435 is 85 percent of 512 rounded down, the span, where green reaches zero.
        send_command(ACT_SMOOTH, 3'd5, 16'd435);
        send_command(ACT_SMOOTH, 3'd6, 16'd100);
        send_command(ACT_DIRECT, 3'd7, 16'h8000);
        drain_and_settle();
    endtask

    // Zero limit, a limit too small for any LED span, the largest limit, and
    // window fields of zero and above the history depth.
    task automatic test_extreme_settings;
        write_register(0, 0);
        write_register(1, 1);
        write_register(2, 2047);
        write_register(3, 100);
        write_register(4, 512);
        write_register(5, 3);
        // Windows per motor from 0 up: 0, 15, 10, 5, 1, 2.
        write_register(int'(REG_WINDOW), 32'h0021_5AF0);
        send_command(ACT_SMOOTH, 3'd0, 16'd1000);
        send_command(ACT_DIRECT, 3'd0, 16'h8000);
        send_command(ACT_DIRECT, 3'd1, 16'd7);
        send_command(ACT_DIRECT, 3'd1, 16'hFFF9);
        send_command(ACT_SMOOTH, 3'd1, 16'd5);
        repeat (3) send_command(ACT_SMOOTH, 3'd2, 16'h7FFF);
        repeat (2) send_command(ACT_SMOOTH, 3'd2, 16'h8000);
        send_command(ACT_DIRECT, 3'd2, 16'd0);
        send_command(ACT_SMOOTH, 3'd3, 16'hFF38);
        send_command(ACT_SMOOTH, 3'd3, 16'd333);
        send_command(ACT_SMOOTH, 3'd4, 16'd1);
        send_command(ACT_SMOOTH, 3'd5, 16'hF801);
        drain_and_settle();
    endtask

    // Slots beyond a shrunk window keep their values and come back into the
    // mean once the window grows again.
    task automatic test_window_shrink;
        write_register(int'(REG_WINDOW), with_window(window_model, 2, 10));
        for (int i = 1; i <= 6; i++) send_command(ACT_SMOOTH, 3'd2, SPEED_W'(i * 1500));
        drain_and_settle();
        write_register(int'(REG_WINDOW), with_window(window_model, 2, 3));
        send_command(ACT_SMOOTH, 3'd2, 16'hF000);
        send_command(ACT_SMOOTH, 3'd2, 16'd77);
        drain_and_settle();
        write_register(int'(REG_WINDOW), with_window(window_model, 2, 10));
        send_command(ACT_SMOOTH, 3'd2, 16'd0);
        send_command(ACT_SMOOTH, 3'd2, 16'd2047);
        drain_and_settle();
    endtask

    // With a window of three the write slot follows the counter modulo
    // three, and the large limit lets most averages through unclamped.
    task automatic test_counter_slots;
        write_register(4, 2047);
        write_register(int'(REG_WINDOW), with_window(window_model, 4, 3));
        for (int i = 0; i < COUNTER_ITEMS; i++) send_command(ACT_SMOOTH, 3'd4, pick_speed(3'd4));
        drain_and_settle();
    endtask

    // New settings for every register, then random commands under the given
    // pressure. Commands for missing motors are sent but not counted.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int sent;
        logic [MOTOR_W-1:0] m;
        logic act;
        for (int k = 0; k < MOTORS; k++) begin
            case ($urandom_range(5))
                0: write_register(k, 0);
                1: write_register(k, 1);
                2: write_register(k, 2047);
                3: write_register(k, $urandom_range(2, 40));
                default: write_register(k, $urandom_range(0, 2047));
            endcase
        end
        write_register(int'(REG_WINDOW), $urandom_range(0, 24'hFF_FFFF));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < RANDOM_PER_PHASE) begin
            m   = ($urandom_range(99) < 6) ? MOTOR_W'($urandom_range(6, 7))
                                           : MOTOR_W'($urandom_range(0, 5));
            act = ($urandom_range(99) < 12) ? ACT_DIRECT : ACT_SMOOTH;
            send_command(act, m, pick_speed(m));
            if (m < MOTORS) sent++;
        end
        drain_and_settle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        for (int k = 0; k < MOTORS; k++) begin
            limit_model[k] = DUTY_BITS'(LIMIT_RESET);
            count_model[k] = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) history_model[k][i] = '0;
        end
        window_model = WINDOW_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extreme_settings();
        test_window_shrink();
        test_counter_slots();
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(24, 24);

        if (mismatches == 0) begin
            $display("motor_speed_smoother_pwm_unit: match");
        end else begin
            $display("motor_speed_smoother_pwm_unit: mismatch");
        end
        $finish;
    end

    // Ends the run as a mismatch if the tests hang.
    initial begin
        #(30_000_000);
        $display("motor_speed_smoother_pwm_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mssp_pkg.sv
hdl/mssp_regs.sv
hdl/mssp_div.sv
hdl/mssp_dp.sv
hdl/mssp_ctrl.sv
hdl/motor_speed_smoother_pwm_unit.sv
test/motor_speed_smoother_pwm_unit_test.sv
